// ===== src/clkmux_pkg.sv =====
package clkmux_pkg;

   localparam int NUM_DIGITS = 6;
   localparam int POS_W      = $clog2(NUM_DIGITS);
   localparam int KEY_POS    = NUM_DIGITS - 1;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_SECOND = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HOLD_TICKS   = 1'b1;

   localparam logic [5:0] SEC_LAST  = 6'd59;
   localparam logic [5:0] MIN_LAST  = 6'd59;
   localparam logic [4:0] HOUR_LAST = 5'd23;

   // time and key overlay after the current tick
   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic       key_shown;
      logic [3:0] key_digit;
   } disp_state_type;

   // tens digit of a value below 64 (compare chain, no divider)
   function automatic logic [3:0] tens_of(input logic [5:0] v);
      logic [3:0] t;
      if (v >= 6'd60)      t = 4'd6;
      else if (v >= 6'd50) t = 4'd5;
      else if (v >= 6'd40) t = 4'd4;
      else if (v >= 6'd30) t = 4'd3;
      else if (v >= 6'd20) t = 4'd2;
      else if (v >= 6'd10) t = 4'd1;
      else                 t = 4'd0;
      return t;
   endfunction

   function automatic logic [3:0] ones_of(input logic [5:0] v);
      logic [5:0] tens_x10;
      logic [5:0] rem;
      tens_x10 = {2'b00, tens_of(v)} * 6'd10;
      rem      = v - tens_x10;
      return rem[3:0];
   endfunction

   // segment pattern, bit0 = a .. bit6 = g; codes above nine are blank
   function automatic logic [6:0] seg_pattern(input logic [3:0] d);
      logic [6:0] s;
      case (d)
         4'd0: s = 7'h3F;
         4'd1: s = 7'h06;
         4'd2: s = 7'h5B;
         4'd3: s = 7'h4F;
         4'd4: s = 7'h66;
         4'd5: s = 7'h6D;
         4'd6: s = 7'h7D;
         4'd7: s = 7'h07;
         4'd8: s = 7'h7F;
         4'd9: s = 7'h6F;
         default: s = 7'h00;
      endcase
      return s;
   endfunction

endpackage

// ===== src/clkmux_time.sv =====
module clkmux_time (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic                      key_press,
   input  logic [3:0]                key_code,
   input  logic [15:0]               ticks_per_second,
   input  logic [15:0]               key_hold_ticks,
   output clkmux_pkg::disp_state_type next_state
);
   import clkmux_pkg::*;

   logic [15:0] prescaler_ff, prescaler_in;
   logic [5:0]  seconds_ff, seconds_in;
   logic [5:0]  minutes_ff, minutes_in;
   logic [4:0]  hours_ff, hours_in;
   logic        key_shown_ff, key_shown_in;
   logic [15:0] key_timer_ff, key_timer_in;
   logic [3:0]  key_digit_ff, key_digit_in;
   logic [15:0] prescaler_inc;
   logic        sec_tick;
   logic        shown_mid;
   logic [15:0] timer_mid;

   always_comb begin
      prescaler_inc = prescaler_ff + 16'd1;
      sec_tick      = (prescaler_inc == ticks_per_second);
      prescaler_in  = sec_tick ? 16'd0 : prescaler_inc;

      seconds_in = seconds_ff;
      minutes_in = minutes_ff;
      hours_in   = hours_ff;
      if (sec_tick) begin
         if (seconds_ff >= SEC_LAST) begin
            seconds_in = 6'd0;
            if (minutes_ff >= MIN_LAST) begin
               minutes_in = 6'd0;
               hours_in   = (hours_ff >= HOUR_LAST) ? 5'd0 : hours_ff + 5'd1;
            end else begin
               minutes_in = minutes_ff + 6'd1;
            end
         end else begin
            seconds_in = seconds_ff + 6'd1;
         end
      end

      // press first, then hold timer count-up
      shown_mid    = key_press ? 1'b1 : key_shown_ff;
      timer_mid    = key_press ? 16'd0 : key_timer_ff;
      key_digit_in = key_press ? key_code : key_digit_ff;
      key_timer_in = timer_mid;
      key_shown_in = shown_mid;
      if (shown_mid) begin
         key_timer_in = timer_mid + 16'd1;
         if (key_timer_in == key_hold_ticks) key_shown_in = 1'b0;
      end

      next_state.hours     = hours_in;
      next_state.minutes   = minutes_in;
      next_state.seconds   = seconds_in;
      next_state.key_shown = key_shown_in;
      next_state.key_digit = key_digit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescaler_ff <= '0;
         seconds_ff   <= '0;
         minutes_ff   <= '0;
         hours_ff     <= '0;
         key_shown_ff <= 1'b0;
         key_timer_ff <= '0;
         key_digit_ff <= '0;
      end else if (accept) begin
         prescaler_ff <= prescaler_in;
         seconds_ff   <= seconds_in;
         minutes_ff   <= minutes_in;
         hours_ff     <= hours_in;
         key_shown_ff <= key_shown_in;
         key_timer_ff <= key_timer_in;
         key_digit_ff <= key_digit_in;
      end
   end

endmodule

// ===== src/clkmux_disp.sv =====
module clkmux_disp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic                                out_taken,
   input  clkmux_pkg::disp_state_type          cur_state,
   output logic                                out_valid,
   output logic [6:0]                          segments,
   output logic [clkmux_pkg::NUM_DIGITS-1:0]   digit_select,
   output logic [4:0]                          hours_now,
   output logic [5:0]                          minutes_now,
   output logic [5:0]                          seconds_now
);
   import clkmux_pkg::*;

   logic [POS_W-1:0]      pos_ff, pos_in, pos_eff;
   logic                  valid_ff;
   logic [6:0]            seg_ff, seg_in;
   logic [NUM_DIGITS-1:0] sel_ff, sel_in;
   logic [4:0]            hours_ff;
   logic [5:0]            minutes_ff, seconds_ff;
   logic [3:0]            digit;
   logic [5:0]            hours_ext;

   always_comb begin
      pos_eff   = (pos_ff >= POS_W'(NUM_DIGITS)) ? '0 : pos_ff;
      hours_ext = {1'b0, cur_state.hours};
      case (pos_eff)
         POS_W'(0): digit = tens_of(hours_ext);
         POS_W'(1): digit = ones_of(hours_ext);
         POS_W'(2): digit = tens_of(cur_state.minutes);
         POS_W'(3): digit = ones_of(cur_state.minutes);
         POS_W'(4): digit = tens_of(cur_state.seconds);
         default:   digit = ones_of(cur_state.seconds);
      endcase
      if (pos_eff == POS_W'(KEY_POS) && cur_state.key_shown) digit = cur_state.key_digit;
      seg_in = seg_pattern(digit);
      sel_in = NUM_DIGITS'(1) << pos_eff;
      pos_in = (pos_eff == POS_W'(NUM_DIGITS - 1)) ? '0 : pos_eff + POS_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         valid_ff <= 1'b0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         valid_ff <= 1'b1;
      end else if (out_taken) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         seg_ff     <= seg_in;
         sel_ff     <= sel_in;
         hours_ff   <= cur_state.hours;
         minutes_ff <= cur_state.minutes;
         seconds_ff <= cur_state.seconds;
      end
   end

   assign out_valid    = valid_ff;
   assign segments     = seg_ff;
   assign digit_select = sel_ff;
   assign hours_now    = hours_ff;
   assign minutes_now  = minutes_ff;
   assign seconds_now  = seconds_ff;

endmodule

// ===== src/clock_with_multiplexed_display.sv =====
// The response to an accepted request is registered. Throughput: one request per cycle
// while rsp_tready is high; the single output register frees when the response is
// taken, so req_tready follows rsp_tready in the same cycle.
// Reset (synchronous, active high): time, prescaler, key overlay and digit
// position clear to zero; ticks_per_second returns to 500, key_hold_ticks to 1000.
module clock_with_multiplexed_display (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] key_code, [7:4] zero
   input  logic        req_tuser,   // [0] key_press
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [6:0] segments, [11:7] hours_now,
                                    // [17:12] minutes_now, [23:18] seconds_now
   output logic [5:0]  rsp_tuser,   // [5:0] digit_select
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [clkmux_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0] csr_data
);
   import clkmux_pkg::*;

   logic [15:0]    ticks_per_second_ff;
   logic [15:0]    key_hold_ticks_ff;
   logic           accept;
   disp_state_type cur_state;
   logic [6:0]     segments;
   logic [4:0]     hours_now;
   logic [5:0]     minutes_now, seconds_now;

   // output slot free, or being emptied this cycle
   assign req_tready = !rsp_tvalid || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_second_ff <= 16'd500;
         key_hold_ticks_ff   <= 16'd1000;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TICKS_PER_SECOND: ticks_per_second_ff <= csr_data;
            CSR_KEY_HOLD_TICKS:   key_hold_ticks_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // prescaler, hh:mm:ss counters and key hold timer
   clkmux_time u_time (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .key_press        (req_tuser),
      .key_code         (req_tdata[3:0]),
      .ticks_per_second (ticks_per_second_ff),
      .key_hold_ticks   (key_hold_ticks_ff),
      .next_state       (cur_state)
   );

   // digit scan, segment decode and response register
   clkmux_disp u_disp (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .out_taken    (rsp_tready),
      .cur_state    (cur_state),
      .out_valid    (rsp_tvalid),
      .segments     (segments),
      .digit_select (rsp_tuser),
      .hours_now    (hours_now),
      .minutes_now  (minutes_now),
      .seconds_now  (seconds_now)
   );

   assign rsp_tdata = {seconds_now, minutes_now, hours_now, segments};

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import clkmux_pkg::*;

   localparam int NUM_PHASES = 8;
   localparam int RAND_PER_PHASE = 100;
   localparam int QUIET_LIMIT = 1000;   // cycles without any handshake
   localparam int SETTLE = 4;           // edges drain waits once the queues are empty

   // Per phase register values. Order matters: the prescaler and hold timer only
   // reset on equality, so a lowered limit stalls them until a 16-bit wrap.
   // Only the last two phases lower ticks_per_second below the running prescaler.
   localparam logic [15:0] PHASE_TPS  [NUM_PHASES] =
      '{16'd1, 16'd1, 16'd2, 16'd3, 16'd500, 16'd65535, 16'd0, 16'd4};
   localparam logic [15:0] PHASE_HOLD [NUM_PHASES] =
      '{16'd3, 16'd1, 16'd0, 16'd20, 16'd1000, 16'd65535, 16'd7, 16'd12};

   // glyphs for 0..9, bit0 = segment a
   localparam logic [6:0] GLYPH [10] =
      '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};

   typedef struct packed {
      logic       press;
      logic [3:0] code;
   } tick_req_type;

   typedef struct packed {
      logic [6:0] segments;
      logic [5:0] select;
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
   } frame_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [3:0] key_code, [7:4] zero
   logic        req_tuser = 1'b0;    // [0] key_press
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // [6:0] segments, [11:7] hours_now,
                                     // [17:12] minutes_now, [23:18] seconds_now
   logic [5:0]  rsp_tuser;           // [5:0] digit_select
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0] csr_data = 16'h0000;

   clock_with_multiplexed_display dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   tick_req_type ticks_pending [$];   // requests not yet presented
   frame_type    frames_due [$];      // predicted responses, oldest first
   int        mismatch_count = 0;
   int        frame_count = 0;
   int        quiet_cycles = 0;
   int        send_gap = 0;
   int        take_stall = 0;
   bit        steady = 1'b0;       // no idling on either side while set

   // model copy of the registers and clock state
   logic [15:0] tps_reg, hold_reg;
   logic [15:0] prescale;
   logic [5:0]  sec, mins;
   logic [4:0]  hrs;
   logic [2:0]  pos;
   logic        overlay_on;
   logic [15:0] overlay_timer;
   logic [3:0]  overlay_digit;
   frame_type   want;

   task automatic note_fail(input string msg);
      $display("ERROR @%0t frame %0d: %s", $time, frame_count, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input int got, input int exp_val);
      if (got != exp_val)
         note_fail($sformatf("%s got %0d, expected %0d", name, got, exp_val));
   endtask

   // one display tick: key first, then prescaler/clock, hold timer, digit mux
   function automatic frame_type predict_display(input logic press, input logic [3:0] code);
      frame_type f;
      logic [3:0] d;
      if (press) begin
         overlay_on    = 1'b1;
         overlay_timer = 16'd0;
         overlay_digit = code;
      end
      prescale = prescale + 16'd1;
      if (prescale == tps_reg) begin
         prescale = 16'd0;
         sec = sec + 6'd1;
         if (sec >= 6'd60) begin
            sec  = 6'd0;
            mins = mins + 6'd1;
            if (mins >= 6'd60) begin
               mins = 6'd0;
               hrs  = hrs + 5'd1;
               if (hrs >= 5'd24) hrs = 5'd0;
            end
         end
      end
      if (overlay_on) begin
         overlay_timer = overlay_timer + 16'd1;
         if (overlay_timer == hold_reg) overlay_on = 1'b0;
      end
      if (pos >= 3'(NUM_DIGITS)) pos = 3'd0;
      case (pos)
         3'd0:    d = 4'(hrs / 5'd10);
         3'd1:    d = 4'(hrs % 5'd10);
         3'd2:    d = 4'(mins / 6'd10);
         3'd3:    d = 4'(mins % 6'd10);
         3'd4:    d = 4'(sec / 6'd10);
         default: d = 4'(sec % 6'd10);
      endcase
      if (pos == 3'(KEY_POS) && overlay_on) d = overlay_digit;
      f.segments = (d < 4'd10) ? GLYPH[d] : 7'h00;   // codes above nine blank
      f.select   = 6'b1 << pos;
      f.hours    = hrs;
      f.minutes  = mins;
      f.seconds  = sec;
      pos = (pos == 3'(NUM_DIGITS - 1)) ? 3'd0 : pos + 3'd1;
      return f;
   endfunction

   // request driver: valid held until taken, then a random gap before the next
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            req_tvalid <= 1'b0;
            send_gap--;
         end else if (ticks_pending.size() != 0) begin
            tick_req_type t;
            t = ticks_pending.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {4'h0, t.code};
            req_tuser  <= t.press;
            send_gap = steady ? 0 : $urandom_range(0, 7);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor: predicts on accepted requests, checks accepted responses,
   // and throttles rsp_tready with a fresh random stall after every response unless steady
   always @(posedge clock) begin
      if (reset) begin
         tps_reg       = 16'd500;
         hold_reg      = 16'd1000;
         prescale      = 16'd0;
         sec           = 6'd0;
         mins          = 6'd0;
         hrs           = 5'd0;
         pos           = 3'd0;
         overlay_on    = 1'b0;
         overlay_timer = 16'd0;
         overlay_digit = 4'd0;
         rsp_tready   <= 1'b0;
         take_stall    = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_TICKS_PER_SECOND)    tps_reg  = csr_data;
            else if (csr_index == CSR_KEY_HOLD_TICKS) hold_reg = csr_data;
         end
         if (req_tvalid && req_tready)
            frames_due.push_back(predict_display(req_tuser, req_tdata[3:0]));
         if (rsp_tvalid && rsp_tready) begin
            if (frames_due.size() == 0) begin
               note_fail("response with no request outstanding");
            end else begin
               want = frames_due.pop_front();
               compare_field("segments",     rsp_tdata[6:0],   want.segments);
               compare_field("digit_select", rsp_tuser,        want.select);
               compare_field("hours_now",    rsp_tdata[11:7],  want.hours);
               compare_field("minutes_now",  rsp_tdata[17:12], want.minutes);
               compare_field("seconds_now",  rsp_tdata[23:18], want.seconds);
            end
            frame_count++;
            take_stall = steady ? 0 : $urandom_range(0, 7);
         end
         if (take_stall > 0) begin
            rsp_tready <= 1'b0;
            take_stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("clock_with_multiplexed_display: mismatch");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // hold off until every request is out and every response is back;
   // checked mid-cycle so the edge's updates have all landed
   task automatic drain;
      do @(negedge clock);
      while (ticks_pending.size() != 0 || req_tvalid || frames_due.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      tick_req_type t;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         // registers change only with the block idle
         drain();
         write_reg(CSR_TICKS_PER_SECOND, PHASE_TPS[ph]);
         write_reg(CSR_KEY_HOLD_TICKS, PHASE_HOLD[ph]);
         steady = (ph == 3) || ($urandom_range(0, 3) == 0);

         if (ph == 0) begin
            // every key code, each press replacing the one still shown
            // (codes above nine blank the last digit)
            for (int n = 0; n < 16; n++) begin
               t.press = 1'b1;
               t.code  = 4'(n);
               ticks_pending.push_back(t);
            end
            // let the hold run out; key_code is don't-care without a press
            for (int n = 0; n < 6; n++) begin
               t.press = 1'b0;
               t.code  = 4'($urandom_range(0, 15));
               ticks_pending.push_back(t);
            end
            t.press = 1'b1;
            t.code  = 4'd9;
            ticks_pending.push_back(t);
            t.press = 1'b0;
            t.code  = 4'd15;
            ticks_pending.push_back(t);
            ticks_pending.push_back(t);
         end else begin
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
               t.press = ($urandom_range(0, 7) == 0);
               t.code  = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(10, 15))
                                                      : 4'($urandom_range(0, 9));
               ticks_pending.push_back(t);
            end
         end
      end

      drain();
      if (mismatch_count == 0)
         $display("clock_with_multiplexed_display: match");
      else
         $display("clock_with_multiplexed_display: mismatch");
      $finish;
   end

endmodule
